// ----- rtl/pixel_color_effect_compose_defines.svh -----
`ifndef PIXEL_COLOR_EFFECT_COMPOSE_DEFINES_SVH
`define PIXEL_COLOR_EFFECT_COMPOSE_DEFINES_SVH

// Property checked on every clock edge outside reset: antecedent implies consequent.
`define PCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent at a later clock edge, checked outside reset.
`define PCE_ASSERT_AFTER3(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error(msg);

`endif

// ----- rtl/pce_pkg.sv -----
`default_nettype none

package pce_pkg;

    localparam int COLOR_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int COEFF_W  = 5;
    localparam int PROD_W   = CHAN_W + COEFF_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [COEFF_W-1:0] COEFF_MAX = COEFF_W'(16);
    localparam logic [CHAN_W-1:0]  CHAN_FULL = '1;

    typedef enum logic [1:0] {
        MODE_NONE       = 2'd0,
        MODE_ALPHA      = 2'd1,
        MODE_BRIGHT_INC = 2'd2,
        MODE_BRIGHT_DEC = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_EFFECT_MODE  = 3'd0,
        REG_COEFF_FIRST  = 3'd1,
        REG_COEFF_SECOND = 3'd2,
        REG_BRIGHT_COEFF = 3'd3,
        REG_BACKDROP     = 3'd4,
        REG_BD_FIRST     = 3'd5,
        REG_BD_SECOND    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        mode_t                effect_mode;
        logic [COEFF_W-1:0]   blend_coeff_first;
        logic [COEFF_W-1:0]   blend_coeff_second;
        logic [COEFF_W-1:0]   bright_coeff;
        logic [COLOR_W-1:0]   backdrop_color;
        logic                 backdrop_is_first;
        logic                 backdrop_is_second;
    } cfg_t;

    // Stage one result: targets resolved against the backdrop.
    typedef struct packed {
        logic               blend_sel;
        logic               top_zero;
        logic [COLOR_W-1:0] top;
        logic [COLOR_W-1:0] c1;
        logic [COLOR_W-1:0] c2;
    } sel_t;

    typedef logic [PROD_W-1:0] prod_t;

    // Stage two result: per-channel products.
    typedef struct packed {
        logic                        blend_sel;
        logic                        top_zero;
        logic [COLOR_W-1:0]          top;
        prod_t [NUM_CHAN-1:0]        a;
        prod_t [NUM_CHAN-1:0]        b;
        prod_t [NUM_CHAN-1:0]        y;
    } prod_stage_t;

    function automatic logic [COEFF_W-1:0] clamp_coeff(input logic [COEFF_W-1:0] v);
        clamp_coeff = (v > COEFF_MAX) ? COEFF_MAX : v;
    endfunction

    // Channel i sits above the low byte: blue, green, red.
    function automatic logic [CHAN_W-1:0] chan(input logic [COLOR_W-1:0] color,
                                               input int unsigned i);
        chan = color[CHAN_W*(i+1) +: CHAN_W];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pixel_color_effect_compose.sv -----
`default_nettype none

// Pixel color effect compose: takes one pixel per clock and returns its final packed
// color (red 31:24, green 23:16, blue 15:8) from the last stage. busy is tied low, so an
// item is taken on every clock where start is high; done marks pixel_color for exactly
// one clock and the receiver must take it then, since nothing holds results back.
// The three register stages are target resolution against the backdrop, the
// 8x5 channel products for blend and brightness, and the final add, saturate and
// select. Configuration through the APB port must only change while no item is in
// flight; the stages read the live registers.
module pixel_color_effect_compose (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] top_color,
    input  wire logic [31:0] first_target_color,
    input  wire logic [31:0] second_target_color,
    // Result side
    output logic             done,
    output logic [31:0]      pixel_color,
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    pce_pkg::cfg_t        cfg;
    logic                 accept;
    logic                 s1_valid;
    pce_pkg::sel_t        s1_sel;
    logic                 s2_valid;
    pce_pkg::prod_stage_t s2_prod;

    // Fully pipelined: never refuse an item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    pce_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 1: resolve missing targets and decide whether to blend.
    pce_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (accept),
        .top      (top_color),
        .c1       (first_target_color),
        .c2       (second_target_color),
        .valid    (s1_valid),
        .sel      (s1_sel)
    );

    // Stage 2: channel products for both blend weights and the brightness step.
    pce_product u_product (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s1_valid),
        .sel      (s1_sel),
        .valid    (s2_valid),
        .prod     (s2_prod)
    );

    // Stage 3: scale down, add, saturate and pick the final color.
    pce_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s2_valid),
        .prod     (s2_prod),
        .valid    (done),
        .color    (pixel_color)
    );

endmodule

`default_nettype wire

// ----- rtl/pce_regs.sv -----
`default_nettype none

module pce_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pce_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pce_pkg::DATA_W-1:0] pwdata,
    output logic      [pce_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output pce_pkg::cfg_t                   cfg
);

    pce_pkg::cfg_t     cfg_reg;
    pce_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = pce_pkg::reg_idx_t'(paddr[pce_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                pce_pkg::REG_EFFECT_MODE:  cfg_reg.effect_mode <= pce_pkg::mode_t'(pwdata[1:0]);
                pce_pkg::REG_COEFF_FIRST:
                    cfg_reg.blend_coeff_first <= pwdata[pce_pkg::COEFF_W-1:0];
                pce_pkg::REG_COEFF_SECOND:
                    cfg_reg.blend_coeff_second <= pwdata[pce_pkg::COEFF_W-1:0];
                pce_pkg::REG_BRIGHT_COEFF:
                    cfg_reg.bright_coeff <= pwdata[pce_pkg::COEFF_W-1:0];
                pce_pkg::REG_BACKDROP:     cfg_reg.backdrop_color <= pwdata;
                pce_pkg::REG_BD_FIRST:     cfg_reg.backdrop_is_first <= pwdata[0];
                pce_pkg::REG_BD_SECOND:    cfg_reg.backdrop_is_second <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            pce_pkg::REG_EFFECT_MODE:  prdata[1:0] = cfg_reg.effect_mode;
            pce_pkg::REG_COEFF_FIRST:
                prdata[pce_pkg::COEFF_W-1:0] = cfg_reg.blend_coeff_first;
            pce_pkg::REG_COEFF_SECOND:
                prdata[pce_pkg::COEFF_W-1:0] = cfg_reg.blend_coeff_second;
            pce_pkg::REG_BRIGHT_COEFF:
                prdata[pce_pkg::COEFF_W-1:0] = cfg_reg.bright_coeff;
            pce_pkg::REG_BACKDROP:     prdata = cfg_reg.backdrop_color;
            pce_pkg::REG_BD_FIRST:     prdata[0] = cfg_reg.backdrop_is_first;
            pce_pkg::REG_BD_SECOND:    prdata[0] = cfg_reg.backdrop_is_second;
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/pce_select.sv -----
`default_nettype none

module pce_select (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pce_pkg::cfg_t               cfg,
    input  wire logic                        in_valid,
    input  wire logic [pce_pkg::COLOR_W-1:0] top,
    input  wire logic [pce_pkg::COLOR_W-1:0] c1,
    input  wire logic [pce_pkg::COLOR_W-1:0] c2,
    output logic                             valid,
    output pce_pkg::sel_t                    sel
);

    logic          valid_reg;
    pce_pkg::sel_t sel_reg;
    pce_pkg::sel_t sel_next;

    // Fall back to the backdrop for a missing target that the backdrop stands in for.
    always_comb
    begin
        sel_next.top      = top;
        sel_next.top_zero = (top == '0);
        sel_next.c1 = ((c1 == '0) && cfg.backdrop_is_first)  ? cfg.backdrop_color : c1;
        sel_next.c2 = ((c2 == '0) && cfg.backdrop_is_second) ? cfg.backdrop_color : c2;
        sel_next.blend_sel = (cfg.effect_mode == pce_pkg::MODE_ALPHA)
                             && (sel_next.c1 != '0) && (sel_next.c2 != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sel_reg <= sel_next;
        end
    end

    assign valid = valid_reg;
    assign sel   = sel_reg;

endmodule

`default_nettype wire

// ----- rtl/pce_product.sv -----
`default_nettype none

module pce_product (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pce_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    input  wire pce_pkg::sel_t sel,
    output logic               valid,
    output pce_pkg::prod_stage_t prod
);

    logic                   valid_reg;
    pce_pkg::prod_stage_t   prod_reg;
    pce_pkg::prod_stage_t   prod_next;
    logic [pce_pkg::COEFF_W-1:0] eva;
    logic [pce_pkg::COEFF_W-1:0] evb;
    logic [pce_pkg::COEFF_W-1:0] evy;

    assign eva = pce_pkg::clamp_coeff(cfg.blend_coeff_first);
    assign evb = pce_pkg::clamp_coeff(cfg.blend_coeff_second);
    assign evy = pce_pkg::clamp_coeff(cfg.bright_coeff);

    always_comb
    begin
        logic [pce_pkg::CHAN_W-1:0] bd_c;
        logic [pce_pkg::CHAN_W-1:0] base;
        prod_next.blend_sel = sel.blend_sel;
        prod_next.top_zero  = sel.top_zero;
        prod_next.top       = sel.top;
        for (int i = 0; i < pce_pkg::NUM_CHAN; i++)
        begin
            prod_next.a[i] = pce_pkg::chan(sel.c1, i) * eva;
            prod_next.b[i] = pce_pkg::chan(sel.c2, i) * evb;
            bd_c = pce_pkg::chan(cfg.backdrop_color, i);
            // Brighten scales the headroom, darken scales the value itself.
            base = (cfg.effect_mode == pce_pkg::MODE_BRIGHT_INC)
                   ? (pce_pkg::CHAN_FULL - bd_c) : bd_c;
            prod_next.y[i] = base * evy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign valid = valid_reg;
    assign prod  = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/pce_mix.sv -----
`default_nettype none

module pce_mix (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pce_pkg::cfg_t        cfg,
    input  wire logic                 in_valid,
    input  wire pce_pkg::prod_stage_t prod,
    output logic                      valid,
    output logic [pce_pkg::COLOR_W-1:0] color
);

    localparam int SHIFT = 4;

    logic                        valid_reg;
    logic [pce_pkg::COLOR_W-1:0] color_reg;
    logic [pce_pkg::COLOR_W-1:0] color_next;
    logic [pce_pkg::COLOR_W-1:0] blend_color;
    logic [pce_pkg::COLOR_W-1:0] bright_color;
    logic [pce_pkg::COLOR_W-1:0] bd_eff;
    logic                        bright_mode;

    // A product is at most 255 * 16, so its top bit is always clear and the
    // scaled value fits a channel.
    always_comb
    begin
        logic [pce_pkg::CHAN_W:0]   sum;
        logic [pce_pkg::CHAN_W-1:0] bd_c;
        logic [pce_pkg::CHAN_W-1:0] delta;
        blend_color  = {pce_pkg::COLOR_W{1'b0}};
        blend_color[pce_pkg::CHAN_W-1:0]  = pce_pkg::CHAN_FULL;
        bright_color = cfg.backdrop_color;
        for (int i = 0; i < pce_pkg::NUM_CHAN; i++)
        begin
            sum = {1'b0, prod.a[i][pce_pkg::PROD_W-2:SHIFT]}
                + {1'b0, prod.b[i][pce_pkg::PROD_W-2:SHIFT]};
            // Saturate the sum at full scale.
            blend_color[pce_pkg::CHAN_W*(i+1) +: pce_pkg::CHAN_W] =
                sum[pce_pkg::CHAN_W] ? pce_pkg::CHAN_FULL : sum[pce_pkg::CHAN_W-1:0];
            bd_c  = pce_pkg::chan(cfg.backdrop_color, i);
            delta = prod.y[i][pce_pkg::PROD_W-2:SHIFT];
            bright_color[pce_pkg::CHAN_W*(i+1) +: pce_pkg::CHAN_W] =
                (cfg.effect_mode == pce_pkg::MODE_BRIGHT_INC) ? (bd_c + delta)
                                                              : (bd_c - delta);
        end
    end

    assign bright_mode = (cfg.effect_mode == pce_pkg::MODE_BRIGHT_INC)
                      || (cfg.effect_mode == pce_pkg::MODE_BRIGHT_DEC);
    assign bd_eff = (bright_mode && cfg.backdrop_is_first) ? bright_color
                                                           : cfg.backdrop_color;

    always_comb
    begin
        if (prod.blend_sel)
        begin
            color_next = blend_color;
        end
        else if (prod.top_zero)
        begin
            color_next = bd_eff;
        end
        else
        begin
            color_next = prod.top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            color_reg <= color_next;
        end
    end

    assign valid = valid_reg;
    assign color = color_reg;

endmodule

`default_nettype wire

// ----- rtl/pce_checker.sv -----
`default_nettype none

`include "pixel_color_effect_compose_defines.svh"

module pce_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        pready,
    input wire logic [31:0] pixel_color
);

    logic accept;
    assign accept = start && !busy;

    `PCE_ASSERT_IMPLY(a_never_busy, 1'b1, !busy, "busy raised")
    `PCE_ASSERT_AFTER3(a_item_done, accept, done, "item produced no result")
    `PCE_ASSERT_IMPLY(a_done_has_item, done, $past(accept, 3), "result without item")
    `PCE_ASSERT_IMPLY(a_pready_high, 1'b1, pready, "pready dropped")
    `PCE_ASSERT_IMPLY(a_color_known, done, !$isunknown(pixel_color), "pixel_color unknown")

endmodule

bind pixel_color_effect_compose pce_checker u_pce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .pready      (pready),
    .pixel_color (pixel_color)
);

`default_nettype wire
